// ===== rtl/hufd_pkg.sv =====
package hufd_pkg;

    localparam int SYMBOL_W   = 8;
    localparam int LENGTH_W   = 6;
    localparam int CODE_W     = 32;
    localparam int SYMBOL_NUM = 256;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                status;
        logic                store_overflow;
    } result_t;

endpackage

// ===== rtl/hufd_ram.sv =====
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hufd_walker.sv =====
module hufd_walker #(
    parameter int NODE_COUNT    = 512,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [hufd_pkg::SYMBOL_W-1:0]  symbol_value,
    input  logic [hufd_pkg::LENGTH_W-1:0]  code_length,
    input  logic [hufd_pkg::CODE_W-1:0]    code_word,
    input  logic                           coded_bit,
    output logic                           res_valid,
    input  logic                           res_ready,
    output hufd_pkg::result_t              res
);

    import hufd_pkg::*;

    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int CNT_W   = $clog2(NODE_COUNT + 1);
    localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);
    localparam int ENTRY_W = 2 * ADDR_W + SYMBOL_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LD_WAIT  = 3'd1;
    localparam logic [2:0] ST_LD_STEP  = 3'd2;
    localparam logic [2:0] ST_LD_NEW   = 3'd3;
    localparam logic [2:0] ST_DC_WAIT1 = 3'd4;
    localparam logic [2:0] ST_DC_WAIT2 = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [SYMBOL_W-1:0] sym_reg, sym_next;
    logic                bit_reg, bit_next;
    logic [ADDR_W-1:0]   node_reg, node_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [ADDR_W-1:0]   walk_reg, walk_next;
    logic                overflow_reg, overflow_next;
    logic                root_valid_reg, root_valid_next;
    logic                rd_root_reg, rd_root_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ENTRY_W-1:0]  rd_entry;

    logic [ADDR_W-1:0]   ent_left, ent_right, slot, rd_left, rd_right, rd_next;
    logic [SYMBOL_W-1:0] ent_sym;
    logic                last_bit;
    logic [LEN_W-1:0]    clamped_len;

    hufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Every node but the root is written in full when it is allocated, so
    // only the root can be read before it was ever written.
    assign rd_entry = (rd_root_reg && !root_valid_reg) ? '0 : rd_data;

    assign ent_sym   = entry_reg[SYMBOL_W-1:0];
    assign ent_left  = entry_reg[SYMBOL_W +: ADDR_W];
    assign ent_right = entry_reg[SYMBOL_W + ADDR_W +: ADDR_W];
    assign slot      = code_reg[0] ? ent_right : ent_left;
    assign last_bit  = (rem_reg == LEN_W'(1));

    assign rd_left  = rd_entry[SYMBOL_W +: ADDR_W];
    assign rd_right = rd_entry[SYMBOL_W + ADDR_W +: ADDR_W];
    assign rd_next  = bit_reg ? rd_right : rd_left;

    always_comb
    begin
        if ({1'b0, code_length} > 7'(MAX_CODE_BITS))
        begin
            clamped_len = LEN_W'(MAX_CODE_BITS);
        end
        else
        begin
            clamped_len = LEN_W'(code_length);
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        entry_next      = entry_reg;
        code_next       = code_reg;
        rem_next        = rem_reg;
        sym_next        = sym_reg;
        bit_next        = bit_reg;
        node_next       = node_reg;
        used_next       = used_reg;
        walk_next       = walk_reg;
        overflow_next   = overflow_reg;
        root_valid_next = root_valid_reg;
        rd_root_next    = rd_root_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = entry_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        res_valid       = 1'b0;
        res.symbol      = '0;
        res.status      = STATUS_OK;
        res.store_overflow = overflow_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                    begin
                        sym_next  = symbol_value;
                        code_next = code_word;
                        rem_next  = clamped_len;
                        cur_next  = '0;
                        if (clamped_len != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_LD_WAIT;
                        end
                    end
                    else
                    begin
                        bit_next   = coded_bit;
                        rd_en      = 1'b1;
                        rd_addr    = walk_reg;
                        state_next = ST_DC_WAIT1;
                    end
                end
            end
            ST_LD_WAIT:
            begin
                entry_next = rd_entry;
                state_next = ST_LD_STEP;
            end
            ST_LD_STEP:
            begin
                if (slot != '0)
                begin
                    cur_next = slot;
                    if (last_bit)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rem_next   = rem_reg - LEN_W'(1);
                        code_next  = code_reg >> 1;
                        rd_en      = 1'b1;
                        rd_addr    = slot;
                        state_next = ST_LD_WAIT;
                    end
                end
                else if (used_reg >= CNT_W'(NODE_COUNT))
                begin
                    overflow_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    // Link the new node into its parent; the node itself is
                    // written in the next cycle.
                    wr_en     = 1'b1;
                    wr_addr   = cur_reg;
                    node_next = used_reg[ADDR_W-1:0];
                    if (code_reg[0])
                    begin
                        wr_data = {used_reg[ADDR_W-1:0], ent_left, ent_sym};
                    end
                    else
                    begin
                        wr_data = {ent_right, used_reg[ADDR_W-1:0], ent_sym};
                    end
                    if (cur_reg == '0)
                    begin
                        root_valid_next = 1'b1;
                    end
                    used_next  = used_reg + CNT_W'(1);
                    state_next = ST_LD_NEW;
                end
            end
            ST_LD_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                wr_data = {{(2 * ADDR_W){1'b0}}, (last_bit ? sym_reg : {SYMBOL_W{1'b0}})};
                entry_next = wr_data;
                cur_next   = node_reg;
                if (last_bit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_next   = rem_reg - LEN_W'(1);
                    code_next  = code_reg >> 1;
                    state_next = ST_LD_STEP;
                end
            end
            ST_DC_WAIT1:
            begin
                if (rd_next == '0)
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_MISS;
                    if (res_ready)
                    begin
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    node_next  = rd_next;
                    rd_en      = 1'b1;
                    rd_addr    = rd_next;
                    state_next = ST_DC_WAIT2;
                end
            end
            ST_DC_WAIT2:
            begin
                if (rd_left == '0 && rd_right == '0)
                begin
                    res_valid  = 1'b1;
                    res.symbol = rd_entry[SYMBOL_W-1:0];
                    if (res_ready)
                    begin
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    walk_next  = node_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rd_en)
        begin
            rd_root_next = (rd_addr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= CNT_W'(1);
            walk_reg       <= '0;
            overflow_reg   <= 1'b0;
            root_valid_reg <= 1'b0;
            rd_root_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            walk_reg       <= walk_next;
            overflow_reg   <= overflow_next;
            root_valid_reg <= root_valid_next;
            rd_root_reg    <= rd_root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        entry_reg <= entry_next;
        code_reg  <= code_next;
        rem_reg   <= rem_next;
        sym_reg   <= sym_next;
        bit_reg   <= bit_next;
        node_reg  <= node_next;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NODE_COUNT) && used_reg != '0)
        else $error("node count out of range");

    a_walk_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(walk_reg) < used_reg)
        else $error("walk position points past the allocated nodes");

    a_write_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_LD_STEP || state_reg == ST_LD_NEW))
        else $error("node store written outside a load");

    a_result_only_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (state_reg == ST_DC_WAIT1 || state_reg == ST_DC_WAIT2))
        else $error("result raised outside a decode");

    a_alloc_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LD_STEP && state_next == ST_LD_NEW)
        |=> (wr_en && CNT_W'(wr_addr) == used_reg - CNT_W'(1)))
        else $error("allocated node not written next cycle");
`endif

endmodule

// ===== rtl/hufd_out_stage.sv =====
module hufd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  hufd_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output hufd_pkg::result_t out_res
);

    import hufd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

// ===== rtl/huffman_tree_bit_decoder.sv =====
// Channel | Direction | tdata (low bit up)                                      | tuser
// s_*     | in        | symbol_value 8, code_length 6, code_word 32, coded_bit 1 | op
// m_*     | out       | symbol 8, store_overflow 1                              | status
//
// A decode beat reads the node at the walk position from the node RAM and, unless
// its branch is missing, reads the child in a second dependent read. A load of L
// code bits (L clamped to MAX_CODE_BITS; a zero-length load does nothing) walks
// existing nodes and makes one where a branch is missing; a full store ends it early.
// Reset empties the tree at once: nodes are written in full when allocated.
// While the output register is full and not taken, a new result holds the walker.
module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT    = 512,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // symbol_value [7:0], code_length [13:8], code_word [45:14], coded_bit [46]
    input  logic [47:0] s_tdata,
    // op [0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol [7:0], store_overflow [8]
    output logic [15:0] m_tdata,
    // status [0]
    output logic        m_tuser
);

    import hufd_pkg::*;

    logic    res_valid, res_ready;
    result_t res, out_res;

    hufd_walker #(
        .NODE_COUNT    (NODE_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .op           (s_tuser),
        .symbol_value (s_tdata[7:0]),
        .code_length  (s_tdata[13:8]),
        .code_word    (s_tdata[45:14]),
        .coded_bit    (s_tdata[46]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    hufd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {7'd0, out_res.store_overflow, out_res.symbol};
    assign m_tuser = out_res.status;

endmodule
